[src/wtba_pkg.sv]
// ----------------------------------------------------------------------------
// wtba_pkg: shared constants for the weighted threshold buffer admission block
// Field widths, register indexes, command and error codes, reset values.
// ----------------------------------------------------------------------------
package wtba_pkg;

    // default sizing of the top level
    localparam int FIFO_DEPTH_DEF  = 256;
    localparam int OCTET_WIDTH_DEF = 24;
    localparam int TIME_WIDTH_DEF  = 32;

    // fixed field widths
    localparam int LEN_W     = 16;
    localparam int NOW_W     = 32;
    localparam int CFG_OCT_W = 24;
    localparam int Z_W       = 16;
    localparam int HOST_W    = 8;
    localparam int SOJ_W     = 32;
    localparam int OUT_OCT_W = 24;
    localparam int OUT_PKT_W = 9;
    localparam int DROP_W    = 32;
    localparam int ERR_W     = 2;
    localparam int DIGIT_W   = 8;

    // stream packing
    localparam int IN_TDATA_W   = LEN_W + NOW_W;
    localparam int IN_TUSER_W   = 2;
    localparam int OUT_FIELDS_W = 1 + 1 + LEN_W + 1 + SOJ_W + OUT_OCT_W + OUT_PKT_W
                                  + DROP_W + DROP_W + ERR_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_OCTETS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCARD_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_FRACTION        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOST_COUNT        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BATCH_HOST_COUNT  = 3'd4;

    localparam logic [CFG_OCT_W-1:0] BUFFER_OCTETS_RST     = 24'd41984;
    localparam logic [CFG_OCT_W-1:0] DISCARD_THRESHOLD_RST = 24'd31488;
    localparam logic [Z_W-1:0]       Z_FRACTION_RST        = 16'd62259;
    localparam logic [HOST_W-1:0]    HOST_COUNT_RST        = 8'd10;
    localparam logic [HOST_W-1:0]    BATCH_HOST_COUNT_RST  = 8'd1;

    // commands and error codes
    localparam logic CMD_ARRIVAL = 1'b0;
    localparam logic CMD_DEPART  = 1'b1;

    localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

endpackage

[src/wtba_mul.sv]
// ----------------------------------------------------------------------------
// wtba_mul: shared iterative multiplier
// Multiplies a wide operand by a narrow factor, one 8-bit factor digit per
// cycle, most significant digit first (Horner form).
// ----------------------------------------------------------------------------
module wtba_mul #(
    parameter int ACC_W = 72,
    parameter int FAC_W = 24
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [ACC_W-1:0] mcand,
    input  logic [FAC_W-1:0] factor,
    output logic [ACC_W-1:0] prod,
    output logic             done
);

    localparam int DIG_N     = (FAC_W + wtba_pkg::DIGIT_W - 1) / wtba_pkg::DIGIT_W;
    localparam int FAC_PAD_W = DIG_N * wtba_pkg::DIGIT_W;
    localparam int CNT_W     = $clog2(DIG_N + 1);

    logic [ACC_W-1:0]             mcand_reg, mcand_next;
    logic [FAC_PAD_W-1:0]         fac_reg, fac_next;
    logic [ACC_W-1:0]             prod_reg, prod_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic                         done_reg, done_next;
    logic [wtba_pkg::DIGIT_W-1:0] digit;
    logic [ACC_W-1:0]             partial;

    always_comb
    begin
        digit      = fac_reg[FAC_PAD_W-1 -: wtba_pkg::DIGIT_W];
        partial    = mcand_reg * ACC_W'(digit);
        mcand_next = mcand_reg;
        fac_next   = fac_reg;
        prod_next  = prod_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        if (start)
        begin
            mcand_next = mcand;
            fac_next   = FAC_PAD_W'(factor);
            prod_next  = '0;
            cnt_next   = CNT_W'(DIG_N);
        end
        else if (cnt_reg != '0)
        begin
            prod_next = (prod_reg << wtba_pkg::DIGIT_W) + partial;
            fac_next  = fac_reg << wtba_pkg::DIGIT_W;
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg <= mcand_next;
        fac_reg   <= fac_next;
        prod_reg  <= prod_next;
    end

    assign prod = prod_reg;
    assign done = done_reg;

endmodule

[src/wtba_fifo.sv]
// ----------------------------------------------------------------------------
// wtba_fifo: packet descriptor store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module wtba_fifo #(
    parameter int DEPTH  = 256,
    parameter int WIDTH  = 49,
    parameter int ADDR_W = 8
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[src/weighted_threshold_buffer_admission.sv]
// ----------------------------------------------------------------------------
// weighted_threshold_buffer_admission: packet buffer with class-weighted discard
// Admits or drops arrivals by an exact cross-multiplied weighted-share test,
// queues admitted descriptors, pops the head on departures.
// ----------------------------------------------------------------------------
// Usage:
//   s_* stream: one transaction per event. s_tuser[0] is the command (0 arrival,
//   1 departure), s_tuser[1] the batch class; s_tdata carries length and time.
//   m_* stream: exactly one result transaction per input transaction, in order.
//   cfg_*: register writes, to be taken only while no transaction is in flight;
//   the user must keep to this, as the block itself does not enforce it.
// Sequencing:
//   departures and arrivals at or below the threshold skip the multiplier;
//   arrivals above the threshold run the shared digit-serial multiplier for
//   4 (batch) or 5 (single) products in turn. s_tready is high only between
//   events.
// Reset: pointers, counts, octet totals and drop counters clear; registers
//   return to their defaults. The descriptor store is not cleared.
// Stall: a result waits in the output register; the next transaction is still
//   accepted and processed, and its commit waits until the output is free.
// ----------------------------------------------------------------------------
module weighted_threshold_buffer_admission #(
    parameter int FIFO_DEPTH  = wtba_pkg::FIFO_DEPTH_DEF,
    parameter int OCTET_WIDTH = wtba_pkg::OCTET_WIDTH_DEF,
    parameter int TIME_WIDTH  = wtba_pkg::TIME_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // packet_length, now
    input  logic [wtba_pkg::IN_TDATA_W-1:0]   s_tdata,
    // command, is_batch
    input  logic [wtba_pkg::IN_TUSER_W-1:0]   s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // admitted, dropped, departed_length, departed_batch, sojourn,
    // occupied_octets, occupied_packets, batch_drop_total, single_drop_total,
    // error_code, zero fill
    output logic [wtba_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                              cfg_we,
    input  logic [wtba_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wtba_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int ADDR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);
    localparam int LEN_W   = wtba_pkg::LEN_W;
    localparam int ENTRY_W = TIME_WIDTH + LEN_W + 1;
    // factor width covers both the octet counters and the 24-bit registers
    localparam int FAC_W   = (OCTET_WIDTH > wtba_pkg::CFG_OCT_W) ? OCTET_WIDTH
                                                                : wtba_pkg::CFG_OCT_W;
    // left side: octets * hosts * octets * 2^16; right side: z * reg * octets * hosts
    localparam int LHS_W   = 2 * OCTET_WIDTH + wtba_pkg::HOST_W + wtba_pkg::Z_W;
    localparam int RHS_W   = OCTET_WIDTH + wtba_pkg::Z_W + wtba_pkg::CFG_OCT_W
                             + wtba_pkg::HOST_W;
    localparam int ACC_W   = (LHS_W > RHS_W) ? LHS_W : RHS_W;

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // multiplier operations, in issue order
    localparam logic [2:0] OP_XH  = 3'd0;  // class octets * host_count
    localparam logic [2:0] OP_TTH = 3'd1;  // * (T - Th)          -> left side
    localparam logic [2:0] OP_ZC  = 3'd2;  // z * |C - Th|
    localparam logic [2:0] OP_T   = 3'd3;  // * T                 -> right side (batch)
    localparam logic [2:0] OP_D   = 3'd4;  // * (H - K)           -> right side (single)

    // control state
    logic [1:0]             state_reg, state_next;
    logic [2:0]             op_reg, op_next;
    logic [ADDR_W-1:0]      head_reg, head_next;
    logic [ADDR_W-1:0]      tail_reg, tail_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [OCTET_WIDTH-1:0] total_reg, total_next;
    logic [OCTET_WIDTH-1:0] batch_oct_reg, batch_oct_next;
    logic [wtba_pkg::DROP_W-1:0] batch_drops_reg, batch_drops_next;
    logic [wtba_pkg::DROP_W-1:0] single_drops_reg, single_drops_next;
    logic                   out_valid_reg, out_valid_next;

    // configuration registers
    logic [wtba_pkg::CFG_OCT_W-1:0] buf_oct_reg;
    logic [wtba_pkg::CFG_OCT_W-1:0] thresh_reg;
    logic [wtba_pkg::Z_W-1:0]       z_reg;
    logic [wtba_pkg::HOST_W-1:0]    host_reg;
    logic [wtba_pkg::HOST_W-1:0]    bhost_reg;

    // item and result payload
    logic                   cmd_reg, cmd_next;
    logic                   batch_reg, batch_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [TIME_WIDTH-1:0]  now_reg, now_next;
    logic                   discard_reg, discard_next;
    logic [ACC_W-1:0]       lhs_reg, lhs_next;
    logic                   out_admitted_reg, out_admitted_next;
    logic                   out_dropped_reg, out_dropped_next;
    logic [LEN_W-1:0]       out_dep_len_reg, out_dep_len_next;
    logic                   out_dep_batch_reg, out_dep_batch_next;
    logic [wtba_pkg::SOJ_W-1:0] out_sojourn_reg, out_sojourn_next;
    logic [wtba_pkg::ERR_W-1:0] out_err_reg, out_err_next;

    // datapath wiring
    logic                   accept;
    logic                   idle;
    logic                   item_batch;
    logic [2:0]             op_sel;
    logic [2:0]             last_op;
    logic [FAC_W-1:0]       t_ext, th_ext, c_ext;
    logic                   c_ge_th;
    logic                   over_th;
    logic [OCTET_WIDTH-1:0] single_oct;
    logic [OCTET_WIDTH-1:0] x_val;
    logic [wtba_pkg::HOST_W-1:0] d_val;
    logic                   mul_start;
    logic [ACC_W-1:0]       mul_mcand;
    logic [FAC_W-1:0]       mul_factor;
    logic [ACC_W-1:0]       mul_prod;
    logic                   mul_done;
    logic [ACC_W-1:0]       lhs_shifted;
    logic                   discard_calc;
    logic                   commit;
    logic                   fifo_wr_en;
    logic [ENTRY_W-1:0]     fifo_wr_data;
    logic [ENTRY_W-1:0]     fifo_rd_data;
    logic [LEN_W-1:0]       rd_len;
    logic                   rd_batch;
    logic [TIME_WIDTH-1:0]  rd_time;
    logic [TIME_WIDTH-1:0]  sojourn_full;
    logic [OCTET_WIDTH:0]   total_sum, batch_sum;
    logic [OCTET_WIDTH-1:0] len_oct;

    // ------------------------------------------------------------------
    // operand selection for the shared multiplier
    // ------------------------------------------------------------------
    assign idle     = (state_reg == ST_IDLE);
    assign s_tready = idle;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        // while idle the operands come straight from the incoming transaction
        item_batch = idle ? s_tuser[1] : batch_reg;
        op_sel     = idle ? OP_XH : (op_reg + 3'd1);
        last_op    = batch_reg ? OP_T : OP_D;
        t_ext      = FAC_W'(total_reg);
        th_ext     = FAC_W'(thresh_reg);
        c_ext      = FAC_W'(buf_oct_reg);
        c_ge_th    = (c_ext >= th_ext);
        over_th    = (t_ext > th_ext);
        single_oct = (total_reg > batch_oct_reg) ? (total_reg - batch_oct_reg) : '0;
        x_val      = item_batch ? batch_oct_reg : single_oct;
        // single class divisor, forced to 1 when batch hosts are not fewer
        d_val      = (host_reg > bhost_reg) ? (host_reg - bhost_reg)
                                            : wtba_pkg::HOST_W'(1);
        case (op_sel)
            OP_XH:
            begin
                mul_mcand  = ACC_W'(x_val);
                mul_factor = FAC_W'(host_reg);
            end
            OP_TTH:
            begin
                mul_mcand  = mul_prod;
                mul_factor = t_ext - th_ext;
            end
            OP_ZC:
            begin
                mul_mcand  = ACC_W'(z_reg);
                mul_factor = c_ge_th ? (c_ext - th_ext) : (th_ext - c_ext);
            end
            OP_T:
            begin
                mul_mcand  = mul_prod;
                mul_factor = t_ext;
            end
            OP_D:
            begin
                mul_mcand  = mul_prod;
                mul_factor = FAC_W'(d_val);
            end
            default:
            begin
                mul_mcand  = '0;
                mul_factor = '0;
            end
        endcase
    end

    assign mul_start = (accept && (s_tuser[0] == wtba_pkg::CMD_ARRIVAL) && over_th)
                    || ((state_reg == ST_MUL) && mul_done && (op_reg != last_op));

    wtba_mul #(
        .ACC_W (ACC_W),
        .FAC_W (FAC_W)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .mcand  (mul_mcand),
        .factor (mul_factor),
        .prod   (mul_prod),
        .done   (mul_done)
    );

    // left side times 2^16 against the right side; when capacity is below
    // the threshold the right side is non-positive: drop unless both are zero
    assign lhs_shifted  = lhs_reg << wtba_pkg::Z_W;
    assign discard_calc = c_ge_th ? (lhs_shifted > mul_prod)
                                  : !((lhs_reg == '0) && (mul_prod == '0));

    // ------------------------------------------------------------------
    // descriptor store
    // ------------------------------------------------------------------
    assign fifo_wr_data = {now_reg, batch_reg, len_reg};

    wtba_fifo #(
        .DEPTH  (FIFO_DEPTH),
        .WIDTH  (ENTRY_W),
        .ADDR_W (ADDR_W)
    ) u_fifo (
        .clk     (clk),
        .wr_en   (fifo_wr_en),
        .wr_addr (tail_reg),
        .wr_data (fifo_wr_data),
        .rd_addr (head_reg),
        .rd_data (fifo_rd_data)
    );

    assign rd_len       = fifo_rd_data[LEN_W-1:0];
    assign rd_batch     = fifo_rd_data[LEN_W];
    assign rd_time      = fifo_rd_data[ENTRY_W-1 -: TIME_WIDTH];
    assign sojourn_full = now_reg - rd_time;
    assign len_oct      = OCTET_WIDTH'(len_reg);
    assign total_sum    = {1'b0, total_reg} + {1'b0, len_oct};
    assign batch_sum    = {1'b0, batch_oct_reg} + {1'b0, len_oct};

    // results commit once the output register is free
    assign commit = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    // ------------------------------------------------------------------
    // sequencer and buffer bookkeeping
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next         = state_reg;
        op_next            = op_reg;
        head_next          = head_reg;
        tail_next          = tail_reg;
        count_next         = count_reg;
        total_next         = total_reg;
        batch_oct_next     = batch_oct_reg;
        batch_drops_next   = batch_drops_reg;
        single_drops_next  = single_drops_reg;
        out_valid_next     = out_valid_reg && !m_tready;
        cmd_next           = cmd_reg;
        batch_next         = batch_reg;
        len_next           = len_reg;
        now_next           = now_reg;
        discard_next       = discard_reg;
        lhs_next           = lhs_reg;
        out_admitted_next  = out_admitted_reg;
        out_dropped_next   = out_dropped_reg;
        out_dep_len_next   = out_dep_len_reg;
        out_dep_batch_next = out_dep_batch_reg;
        out_sojourn_next   = out_sojourn_reg;
        out_err_next       = out_err_reg;
        fifo_wr_en         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next     = s_tuser[0];
                    batch_next   = s_tuser[1];
                    len_next     = s_tdata[LEN_W-1:0];
                    now_next     = TIME_WIDTH'(s_tdata[LEN_W +: wtba_pkg::NOW_W]);
                    discard_next = 1'b0;
                    op_next      = OP_XH;
                    if ((s_tuser[0] == wtba_pkg::CMD_ARRIVAL) && over_th)
                    begin
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    if (op_reg == OP_TTH)
                    begin
                        lhs_next = mul_prod;
                    end
                    if (op_reg == last_op)
                    begin
                        discard_next = discard_calc;
                        state_next   = ST_DONE;
                    end
                    else
                    begin
                        op_next = op_reg + 3'd1;
                    end
                end
            end
            ST_DONE:
            begin
                if (commit)
                begin
                    state_next         = ST_IDLE;
                    out_valid_next     = 1'b1;
                    out_admitted_next  = 1'b0;
                    out_dropped_next   = 1'b0;
                    out_dep_len_next   = '0;
                    out_dep_batch_next = 1'b0;
                    out_sojourn_next   = '0;
                    out_err_next       = wtba_pkg::ERR_NONE;
                    if (cmd_reg == wtba_pkg::CMD_ARRIVAL)
                    begin
                        if (discard_reg)
                        begin
                            out_dropped_next = 1'b1;
                        end
                        else if (count_reg == CNT_W'(FIFO_DEPTH))
                        begin
                            out_dropped_next = 1'b1;
                            out_err_next     = wtba_pkg::ERR_FULL;
                        end
                        else
                        begin
                            out_admitted_next = 1'b1;
                            fifo_wr_en        = 1'b1;
                            tail_next  = (tail_reg == ADDR_W'(FIFO_DEPTH - 1)) ? '0
                                                                               : tail_reg + 1'b1;
                            count_next = count_reg + 1'b1;
                            total_next = total_sum[OCTET_WIDTH] ? '1
                                                                : total_sum[OCTET_WIDTH-1:0];
                            if (batch_reg)
                            begin
                                batch_oct_next = batch_sum[OCTET_WIDTH] ? '1
                                                                        : batch_sum[OCTET_WIDTH-1:0];
                            end
                        end
                        if (out_dropped_next)
                        begin
                            if (batch_reg)
                            begin
                                batch_drops_next = batch_drops_reg + 1'b1;
                            end
                            else
                            begin
                                single_drops_next = single_drops_reg + 1'b1;
                            end
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        out_err_next = wtba_pkg::ERR_EMPTY;
                    end
                    else
                    begin
                        out_dep_len_next   = rd_len;
                        out_dep_batch_next = rd_batch;
                        out_sojourn_next   = wtba_pkg::SOJ_W'(sojourn_full);
                        head_next  = (head_reg == ADDR_W'(FIFO_DEPTH - 1)) ? '0
                                                                           : head_reg + 1'b1;
                        count_next = count_reg - 1'b1;
                        total_next = (total_reg > OCTET_WIDTH'(rd_len))
                                   ? (total_reg - OCTET_WIDTH'(rd_len)) : '0;
                        if (rd_batch)
                        begin
                            batch_oct_next = (batch_oct_reg > OCTET_WIDTH'(rd_len))
                                           ? (batch_oct_reg - OCTET_WIDTH'(rd_len)) : '0;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            op_reg           <= OP_XH;
            head_reg         <= '0;
            tail_reg         <= '0;
            count_reg        <= '0;
            total_reg        <= '0;
            batch_oct_reg    <= '0;
            batch_drops_reg  <= '0;
            single_drops_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            op_reg           <= op_next;
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            count_reg        <= count_next;
            total_reg        <= total_next;
            batch_oct_reg    <= batch_oct_next;
            batch_drops_reg  <= batch_drops_next;
            single_drops_reg <= single_drops_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg           <= cmd_next;
        batch_reg         <= batch_next;
        len_reg           <= len_next;
        now_reg           <= now_next;
        discard_reg       <= discard_next;
        lhs_reg           <= lhs_next;
        out_admitted_reg  <= out_admitted_next;
        out_dropped_reg   <= out_dropped_next;
        out_dep_len_reg   <= out_dep_len_next;
        out_dep_batch_reg <= out_dep_batch_next;
        out_sojourn_reg   <= out_sojourn_next;
        out_err_reg       <= out_err_next;
    end

    // configuration writes, no handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_oct_reg <= wtba_pkg::BUFFER_OCTETS_RST;
            thresh_reg  <= wtba_pkg::DISCARD_THRESHOLD_RST;
            z_reg       <= wtba_pkg::Z_FRACTION_RST;
            host_reg    <= wtba_pkg::HOST_COUNT_RST;
            bhost_reg   <= wtba_pkg::BATCH_HOST_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                wtba_pkg::CFG_BUFFER_OCTETS:
                    buf_oct_reg <= wtba_pkg::CFG_OCT_W'(cfg_data);
                wtba_pkg::CFG_DISCARD_THRESHOLD:
                    thresh_reg <= wtba_pkg::CFG_OCT_W'(cfg_data);
                wtba_pkg::CFG_Z_FRACTION:
                    z_reg <= wtba_pkg::Z_W'(cfg_data);
                wtba_pkg::CFG_HOST_COUNT:
                    host_reg <= wtba_pkg::HOST_W'(cfg_data);
                wtba_pkg::CFG_BATCH_HOST_COUNT:
                    bhost_reg <= wtba_pkg::HOST_W'(cfg_data);
                default:
                    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // result stream; occupancy and drop totals are read from live state,
    // which only moves when a new result is loaded
    // ------------------------------------------------------------------
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(wtba_pkg::OUT_PAD_W){1'b0}},
                       out_err_reg,
                       single_drops_reg,
                       batch_drops_reg,
                       wtba_pkg::OUT_PKT_W'(count_reg),
                       wtba_pkg::OUT_OCT_W'(total_reg),
                       out_sojourn_reg,
                       out_dep_batch_reg,
                       out_dep_len_reg,
                       out_dropped_reg,
                       out_admitted_reg};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == tail_reg))
        else $error("empty buffer with head and tail apart");

    a_empty_octets: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> ((total_reg == '0) && (batch_oct_reg == '0)))
        else $error("octets left over in an empty buffer");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(out_admitted_reg && out_dropped_reg))
        else $error("result both admitted and dropped");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (out_err_reg == wtba_pkg::ERR_FULL)) |-> out_dropped_reg)
        else $error("full error without a drop");

    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && (cmd_reg == wtba_pkg::CMD_DEPART) && (count_reg == '0))
        |=> ((count_reg == '0) && $stable(head_reg)))
        else $error("departure from empty moved the buffer");

endmodule

[verif/wtba_admission_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtba_admission_checker: result checker for the buffer admission block
// Watches the event, result and register channels. Keeps its own copy of the
// buffer state, predicts one result per accepted event and compares the
// results in order, field by field.
// ----------------------------------------------------------------------------
module wtba_admission_checker
    import wtba_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic [IN_TUSER_W-1:0]  s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     fail_count = 0,
    output int                     outstanding = 0
);

    localparam int DEPTH = FIFO_DEPTH_DEF;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int MAX_PRINTS = 40;
    localparam logic [OUT_OCT_W-1:0] OCT_MAX = '1;

    // packed MSB first, so admitted lands in bit 0 of the stream word
    typedef struct packed {
        logic [ERR_W-1:0]     error_code;
        logic [DROP_W-1:0]    single_drop_total;
        logic [DROP_W-1:0]    batch_drop_total;
        logic [OUT_PKT_W-1:0] occupied_packets;
        logic [OUT_OCT_W-1:0] occupied_octets;
        logic [SOJ_W-1:0]     sojourn;
        logic                 departed_batch;
        logic [LEN_W-1:0]     departed_length;
        logic                 dropped;
        logic                 admitted;
    } admission_result_t;

    // register copies
    logic [CFG_OCT_W-1:0] capacity;
    logic [CFG_OCT_W-1:0] threshold;
    logic [Z_W-1:0]       z_frac;
    logic [HOST_W-1:0]    hosts;
    logic [HOST_W-1:0]    batch_hosts;

    // buffer state
    logic [LEN_W-1:0]     held_len   [DEPTH];
    logic                 held_batch [DEPTH];
    logic [NOW_W-1:0]     held_time  [DEPTH];
    logic [PTR_W-1:0]     head_slot;
    logic [PTR_W-1:0]     tail_slot;
    logic [OUT_PKT_W-1:0] held_count;
    logic [OUT_OCT_W-1:0] occ_octets;
    logic [OUT_OCT_W-1:0] batch_octets;
    logic [DROP_W-1:0]    batch_drops;
    logic [DROP_W-1:0]    single_drops;

    admission_result_t pending_results[$];
    int results_seen = 0;

    function automatic logic [PTR_W-1:0] next_slot(logic [PTR_W-1:0] slot);
        return (slot == PTR_W'(DEPTH - 1)) ? '0 : slot + 1'b1;
    endfunction

    // weighted share test, cross-multiplied so no division is needed
    function automatic logic share_exceeded(logic batch);
        logic [127:0]         lhs;
        logic [127:0]         rhs;
        logic [OUT_OCT_W-1:0] share;
        logic [OUT_OCT_W-1:0] excess;
        logic [CFG_OCT_W-1:0] span;
        logic [HOST_W-1:0]    divisor;
        if (occ_octets <= threshold)
            return 1'b0;
        divisor = (hosts > batch_hosts) ? hosts - batch_hosts : 8'd1;
        if (batch)
            share = batch_octets;
        else
            share = (occ_octets > batch_octets) ? occ_octets - batch_octets : '0;
        excess = occ_octets - threshold;
        span   = (capacity >= threshold) ? capacity - threshold : threshold - capacity;
        lhs = 128'(share) * 128'(hosts) * 128'(excess) * 128'(65536);
        rhs = 128'(z_frac) * 128'(span) * 128'(occ_octets);
        if (!batch)
            rhs = rhs * 128'(divisor);
        if (capacity >= threshold)
            return lhs > rhs;
        // capacity under threshold: only an all-zero comparison survives
        return !(lhs == '0 && rhs == '0);
    endfunction

    function automatic admission_result_t predict_admission(logic cmd, logic [LEN_W-1:0] len,
                                                            logic batch, logic [NOW_W-1:0] now);
        admission_result_t r;
        logic [OUT_OCT_W:0] sum;
        logic [LEN_W-1:0]   out_len;
        r = '0;
        r.error_code = ERR_NONE;
        if (cmd == CMD_ARRIVAL) begin
            if (share_exceeded(batch)) begin
                r.dropped = 1'b1;
            end
            else if (held_count >= OUT_PKT_W'(DEPTH)) begin
                r.dropped    = 1'b1;
                r.error_code = ERR_FULL;
            end
            else begin
                held_len[tail_slot]   = len;
                held_batch[tail_slot] = batch;
                held_time[tail_slot]  = now;
                tail_slot  = next_slot(tail_slot);
                held_count = held_count + 1'b1;
                sum = {1'b0, occ_octets} + len;
                occ_octets = (sum > {1'b0, OCT_MAX}) ? OCT_MAX : sum[OUT_OCT_W-1:0];
                if (batch) begin
                    sum = {1'b0, batch_octets} + len;
                    batch_octets = (sum > {1'b0, OCT_MAX}) ? OCT_MAX : sum[OUT_OCT_W-1:0];
                end
                r.admitted = 1'b1;
            end
            if (r.dropped) begin
                if (batch)
                    batch_drops = batch_drops + 1'b1;
                else
                    single_drops = single_drops + 1'b1;
            end
        end
        else if (held_count == '0) begin
            r.error_code = ERR_EMPTY;
        end
        else begin
            out_len           = held_len[head_slot];
            r.departed_length = out_len;
            r.departed_batch  = held_batch[head_slot];
            r.sojourn         = now - held_time[head_slot];
            head_slot  = next_slot(head_slot);
            held_count = held_count - 1'b1;
            occ_octets = (occ_octets > out_len) ? occ_octets - out_len : '0;
            if (r.departed_batch)
                batch_octets = (batch_octets > out_len) ? batch_octets - out_len : '0;
        end
        r.occupied_octets   = occ_octets;
        r.occupied_packets  = held_count;
        r.batch_drop_total  = batch_drops;
        r.single_drop_total = single_drops;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (fail_count < MAX_PRINTS)
            $display("%0t result %0d: %s got 0x%0h expected 0x%0h",
                     $time, results_seen, what, got, want);
        fail_count++;
    endtask

    task automatic compare_result(admission_result_t got, admission_result_t want);
        if (got.admitted !== want.admitted)
            report_mismatch("admitted", got.admitted, want.admitted);
        if (got.dropped !== want.dropped)
            report_mismatch("dropped", got.dropped, want.dropped);
        if (got.departed_length !== want.departed_length)
            report_mismatch("departed_length", got.departed_length, want.departed_length);
        if (got.departed_batch !== want.departed_batch)
            report_mismatch("departed_batch", got.departed_batch, want.departed_batch);
        if (got.sojourn !== want.sojourn)
            report_mismatch("sojourn", got.sojourn, want.sojourn);
        if (got.occupied_octets !== want.occupied_octets)
            report_mismatch("occupied_octets", got.occupied_octets, want.occupied_octets);
        if (got.occupied_packets !== want.occupied_packets)
            report_mismatch("occupied_packets", got.occupied_packets, want.occupied_packets);
        if (got.batch_drop_total !== want.batch_drop_total)
            report_mismatch("batch_drop_total", got.batch_drop_total, want.batch_drop_total);
        if (got.single_drop_total !== want.single_drop_total)
            report_mismatch("single_drop_total", got.single_drop_total,
                            want.single_drop_total);
        if (got.error_code !== want.error_code)
            report_mismatch("error_code", got.error_code, want.error_code);
    endtask

    // all channels sampled at the edge, before the edge's own updates land
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            capacity     = BUFFER_OCTETS_RST;
            threshold    = DISCARD_THRESHOLD_RST;
            z_frac       = Z_FRACTION_RST;
            hosts        = HOST_COUNT_RST;
            batch_hosts  = BATCH_HOST_COUNT_RST;
            head_slot    = '0;
            tail_slot    = '0;
            held_count   = '0;
            occ_octets   = '0;
            batch_octets = '0;
            batch_drops  = '0;
            single_drops = '0;
            pending_results.delete();
            outstanding <= 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_BUFFER_OCTETS:     capacity    = cfg_data[CFG_OCT_W-1:0];
                    CFG_DISCARD_THRESHOLD: threshold   = cfg_data[CFG_OCT_W-1:0];
                    CFG_Z_FRACTION:        z_frac      = cfg_data[Z_W-1:0];
                    CFG_HOST_COUNT:        hosts       = cfg_data[HOST_W-1:0];
                    CFG_BATCH_HOST_COUNT:  batch_hosts = cfg_data[HOST_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0)
                    report_mismatch("result with nothing pending", m_tdata[63:0], '0);
                else
                    compare_result(m_tdata[OUT_FIELDS_W-1:0], pending_results.pop_front());
                if (m_tdata[OUT_TDATA_W-1:OUT_FIELDS_W] !== '0)
                    report_mismatch("zero fill", m_tdata[OUT_TDATA_W-1:OUT_FIELDS_W], '0);
                results_seen++;
            end
            if (s_tvalid && s_tready)
                pending_results.push_back(predict_admission(s_tuser[0], s_tdata[LEN_W-1:0],
                                                            s_tuser[1],
                                                            s_tdata[LEN_W +: NOW_W]));
            outstanding <= pending_results.size();
        end
    end

endmodule

[verif/tb_weighted_threshold_buffer_admission.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_weighted_threshold_buffer_admission: testbench top for the buffer manager
// Drives arrival and departure events through a series of register settings,
// stalls both stream sides at random and leaves checking to the checker.
// ----------------------------------------------------------------------------
module tb_weighted_threshold_buffer_admission;
    import wtba_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    // waits past the slowest event at default sizing, with room on top
    localparam int IDLE_GAP = 32;
    // no register lives here; writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    // packet_length, now
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    // command, is_batch
    logic [IN_TUSER_W-1:0]  s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // admitted, dropped, departed_length, departed_batch, sojourn,
    // occupied_octets, occupied_packets, batch_drop_total, single_drop_total,
    // error_code, zero fill
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int fail_count;
    int outstanding;

    // traffic shape, set per phase
    int          depart_pct  = 45;
    int          batch_pct   = 40;
    int          max_len     = 1000;
    int          gap_pct     = 30;
    int          ready_pct   = 80;
    int          stall_left  = 0;
    int          cycles      = 0;
    logic [31:0] clock_ticks = '0;

    always #4 clk = ~clk;

    weighted_threshold_buffer_admission u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    wtba_admission_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Result side backpressure. Mostly ready at ready_pct; a refusal starts a
    // stall, drawn from the long range of lengths for one refusal in ten.
    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if ($urandom_range(0, 99) < ready_pct) begin
            m_tready <= 1'b1;
        end
        else begin
            m_tready   <= 1'b0;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                      : $urandom_range(0, 2);
        end
    end

    // watchdog: a hang anywhere ends the run as a failure
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL weighted_threshold_buffer_admission");
            $finish;
        end
    end

    // idle cycles ahead of the next event: mostly none, some short, few long
    function automatic int pick_gap();
        if ($urandom_range(0, 99) >= gap_pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // One event transaction. Called just after a rising edge and returns just
    // after the edge that took it, so back-to-back events keep valid high
    // without a lower/raise in the same step.
    task automatic send_event(logic cmd, logic [LEN_W-1:0] len, logic batch,
                              logic [NOW_W-1:0] now, int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {now, len};
        s_tuser  <= {batch, cmd};
        do @(posedge clk); while (!s_tready);
    endtask

    // Random event. Lengths mostly scaled to the phase so that occupancy
    // climbs past the threshold, with the field extremes and full-width values
    // mixed in. Time mostly creeps forward; a jump now and then wraps it.
    task automatic send_random_event(bit arrival_only);
        logic             cmd;
        logic [LEN_W-1:0] len;
        logic             batch;
        int               pick;
        cmd   = (!arrival_only && $urandom_range(0, 99) < depart_pct) ? CMD_DEPART : CMD_ARRIVAL;
        batch = ($urandom_range(0, 99) < batch_pct);
        pick  = $urandom_range(0, 19);
        case (pick)
            0:       len = '0;
            1:       len = '1;
            2:       len = LEN_W'($urandom);
            default: len = LEN_W'($urandom_range(0, max_len));
        endcase
        if ($urandom_range(0, 49) == 0)
            clock_ticks = $urandom;
        else
            clock_ticks = clock_ticks + $urandom_range(0, 2000);
        send_event(cmd, len, batch, clock_ticks, pick_gap());
    endtask

    // Wait for every expected result, then let the block settle. The count
    // from the checker is registered, so look only after a further edge.
    task automatic wait_idle();
        do @(posedge clk); while (outstanding != 0);
        repeat (IDLE_GAP) @(posedge clk);
    endtask

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // all five registers in one burst; write enable rises and falls once
    task automatic program_regs(logic [CFG_OCT_W-1:0] cap, logic [CFG_OCT_W-1:0] thresh,
                                logic [Z_W-1:0] zf, logic [HOST_W-1:0] host_n,
                                logic [HOST_W-1:0] batch_n);
        cfg_we <= 1'b1;
        put_reg(CFG_BUFFER_OCTETS, cap);
        put_reg(CFG_DISCARD_THRESHOLD, thresh);
        put_reg(CFG_Z_FRACTION, CFG_DATA_W'(zf));
        put_reg(CFG_HOST_COUNT, CFG_DATA_W'(host_n));
        put_reg(CFG_BATCH_HOST_COUNT, CFG_DATA_W'(batch_n));
        cfg_we <= 1'b0;
    endtask

    // One phase: drain, reprogram, then traffic. The first fill_n events are
    // arrivals only, to push the queue to its depth.
    task automatic run_phase(logic [CFG_OCT_W-1:0] cap, logic [CFG_OCT_W-1:0] thresh,
                             logic [Z_W-1:0] zf, logic [HOST_W-1:0] host_n,
                             logic [HOST_W-1:0] batch_n, int len_cap, int dep_pct,
                             int fill_n, int count, int gaps, int ready);
        wait_idle();
        program_regs(cap, thresh, zf, host_n, batch_n);
        max_len    = len_cap;
        depart_pct = dep_pct;
        gap_pct    = gaps;
        ready_pct  = ready;
        batch_pct  = $urandom_range(20, 70);
        for (int i = 0; i < count; i++)
            send_random_event(i < fill_n);
        s_tvalid <= 1'b0;
    endtask

    initial begin
        logic [CFG_OCT_W-1:0] cap;
        logic [CFG_OCT_W-1:0] thresh;
        logic [HOST_W-1:0]    host_n;
        logic [HOST_W-1:0]    batch_n;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed events at reset settings: departure from an empty buffer,
        // length and time extremes, both classes, arrivals that push occupancy
        // over the threshold, a sojourn that wraps through zero, and draining
        // back to empty.
        send_event(CMD_DEPART,  16'h1234, 1'b1, 32'h0000_0010, 0);
        send_event(CMD_ARRIVAL, 16'h0000, 1'b0, 32'h0000_0000, 0);
        send_event(CMD_ARRIVAL, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 0);
        send_event(CMD_ARRIVAL, 16'd40000, 1'b0, 32'h0000_0064, 0);
        send_event(CMD_ARRIVAL, 16'd1000, 1'b1, 32'h0000_0065, 0);
        send_event(CMD_ARRIVAL, 16'd1, 1'b0, 32'h0000_0066, 0);
        send_event(CMD_ARRIVAL, 16'hFFFF, 1'b1, 32'h8000_0000, 0);
        send_event(CMD_ARRIVAL, 16'hFFFF, 1'b0, 32'h7FFF_FFFF, 0);
        send_event(CMD_DEPART,  16'hFFFF, 1'b0, 32'h0000_000A, 0);
        send_event(CMD_DEPART,  16'h0000, 1'b1, 32'h0000_0003, 0);
        send_event(CMD_DEPART,  16'hAAAA, 1'b0, 32'h5555_5555, 0);
        send_event(CMD_DEPART,  16'h5555, 1'b1, 32'hAAAA_AAAA, 0);
        send_event(CMD_DEPART,  16'h0000, 1'b0, 32'hFFFF_FFFF, 0);
        send_event(CMD_DEPART,  16'h0000, 1'b0, 32'h0000_0000, 0);
        send_event(CMD_DEPART,  16'hFFFF, 1'b1, 32'h1234_5678, 0);
        send_event(CMD_DEPART,  16'h0001, 1'b0, 32'h0000_0001, 0);
        s_tvalid <= 1'b0;

        // a write to an index with no register behind it
        wait_idle();
        cfg_we <= 1'b1;
        put_reg(CFG_NO_REG, '1);
        cfg_we <= 1'b0;

        // reset values written back explicitly, ordinary traffic
        run_phase(24'd41984, 24'd31488, 16'd62259, 8'd10, 8'd1, 9000, 45, 0, 150, 30, 80);
        // small buffer, no idling on either side
        run_phase(24'd3000, 24'd1000, 16'd32768, 8'd4, 8'd2, 1500, 45, 0, 150, 0, 100);
        // every register at its top end but batch hosts at 254, threshold at zero
        run_phase(24'hFF_FFFF, 24'd0, 16'hFFFF, 8'd255, 8'd254, 65535, 50, 0, 120, 30, 60);
        // threshold out of reach: the queue fills to its depth and overflows
        run_phase(24'd1, 24'hFF_FFFF, 16'd0, 8'd2, 8'd1, 65535, 60, 280, 330, 20, 85);
        // capacity under threshold with z zero, batch hosts equal to hosts
        run_phase(24'd500, 24'd2000, 16'd0, 8'd8, 8'd8, 1500, 45, 0, 120, 30, 70);
        // capacity under threshold, batch hosts above hosts
        run_phase(24'd1, 24'd100, 16'hFFFF, 8'd3, 8'd200, 200, 45, 0, 100, 40, 50);
        // everything at the bottom: zero capacity and threshold, one host
        run_phase(24'd0, 24'd0, 16'd1, 8'd1, 8'd0, 3000, 40, 0, 100, 30, 80);

        // random settings around the thresholds that the traffic can reach
        for (int p = 0; p < 4; p++) begin
            thresh  = $urandom_range(0, 60000);
            cap     = ($urandom_range(0, 3) == 0) ? $urandom_range(1, thresh + 1)
                                                  : thresh + $urandom_range(0, 50000);
            host_n  = $urandom_range(2, 255);
            batch_n = ($urandom_range(0, 9) == 0) ? $urandom_range(host_n, 255)
                                                  : $urandom_range(1, host_n - 1);
            run_phase(cap, thresh, $urandom_range(0, 65535), host_n, batch_n,
                      $urandom_range(200, 20000), $urandom_range(35, 55), 0, 60,
                      $urandom_range(0, 50), $urandom_range(40, 100));
        end

        wait_idle();
        if (fail_count == 0 && outstanding == 0)
            $display("PASS weighted_threshold_buffer_admission");
        else
            $display("FAIL weighted_threshold_buffer_admission");
        $finish;
    end

endmodule

[sim.f]
src/wtba_pkg.sv
src/wtba_mul.sv
src/wtba_fifo.sv
src/weighted_threshold_buffer_admission.sv
verif/wtba_admission_checker.sv
verif/tb_weighted_threshold_buffer_admission.sv
